>>> rtl/periodic_task_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// periodic task scheduler assertion macros
// Clocked assertion wrappers for the scheduler RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// plain property, sampled on clk, off during reset
`define PTS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define PTS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define PTS_ASSERT(name, prop, msg)
`define PTS_ASSERT_IMPL(name, ante, cons, msg)

`endif

`endif

>>> rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, codes and result type of the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	// parameter defaults
	localparam int SLOTS_DEFAULT   = 16;
	localparam int ID_BITS_DEFAULT = 16;

	// fixed field widths
	localparam int KIND_W     = 2;
	localparam int TIME_W     = 32;
	localparam int TASK_ID_W  = 16;
	localparam int SLOT_OUT_W = 4;

	// input item kinds
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

	// result item kinds
	localparam logic [KIND_W-1:0] RES_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] RES_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] RES_FIRED  = 2'd2;
	localparam logic [KIND_W-1:0] RES_DONE   = 2'd3;

	// last poll time after reset
	localparam logic [TIME_W-1:0] POLL_RESET = '1;

	// one result item
	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  ok;
		logic [TASK_ID_W-1:0]  id;
		logic [TIME_W-1:0]     late;
		logic                  last;
	} rsp_t;

endpackage

>>> rtl/periodic_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// periodic task scheduler unit
// Slot table of periodic tasks with add, remove and tick-driven firing.
// ----------------------------------------------------------------------------
// A sequencer walks the slot table one slot per cycle, waiting at a due slot
// while the result register is stalled, through a single read port of the
// table memory; one 32-bit adder computes lateness, new due times and first
// due times. A tick with a new time scans every slot and spends an extra
// step on each fired slot; a repeated tick time goes straight to the done
// result; an add or remove stops its scan when the id is found. The block
// takes no item while one is in work, but accepts the next item while the
// last result still waits in the output register.
// ----------------------------------------------------------------------------
`include "periodic_task_scheduler_unit_assert.svh"

module periodic_task_scheduler_unit #(
	parameter int SLOTS   = pts_pkg::SLOTS_DEFAULT,
	parameter int ID_BITS = pts_pkg::ID_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [pts_pkg::KIND_W-1:0]          kind,
	input  logic signed [pts_pkg::TIME_W-1:0]   now_ticks,
	input  logic [pts_pkg::TASK_ID_W-1:0]       task_id,
	input  logic signed [pts_pkg::TIME_W-1:0]   period,
	input  logic signed [pts_pkg::TIME_W-1:0]   start_delay,
	// result channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [pts_pkg::KIND_W-1:0]          result_kind,
	output logic [pts_pkg::SLOT_OUT_W-1:0]      slot,
	output logic                                ok,
	output logic [pts_pkg::TASK_ID_W-1:0]       fired_id,
	output logic signed [pts_pkg::TIME_W-1:0]   lateness,
	output logic                                last
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_FIRE  = 6'b000100,
		S_PLACE = 6'b001000,
		S_REPLY = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                       state_q, state_d;
	logic [SLOT_W-1:0]            idx_q, idx_d;
	logic [SLOT_W-1:0]            pick_q, pick_d;
	logic                         have_pick_q, have_pick_d;
	logic                         ok_q, ok_d;
	logic [pts_pkg::TIME_W-1:0]   last_poll_q;
	logic [SLOTS-1:0]             valid_q;

	// captured item
	logic [pts_pkg::KIND_W-1:0]   kind_q;
	logic signed [pts_pkg::TIME_W-1:0] now_q;
	logic [ID_BITS-1:0]           id_q;
	logic [pts_pkg::TIME_W-1:0]   per_q;
	logic [pts_pkg::TIME_W-1:0]   dly_q;

	// slot table memory
	logic [ID_BITS-1:0]           key_mem [SLOTS];
	logic [pts_pkg::TIME_W-1:0]   per_mem [SLOTS];
	logic [pts_pkg::TIME_W-1:0]   due_mem [SLOTS];
	logic [ID_BITS-1:0]           key_rd_q;
	logic [pts_pkg::TIME_W-1:0]   per_rd_q;
	logic signed [pts_pkg::TIME_W-1:0] due_rd_q;
	logic [SLOT_W-1:0]            rd_addr;
	logic [SLOT_W-1:0]            wr_addr;
	logic                         slot_wr;
	logic                         due_wr;
	logic                         vld_set;
	logic                         vld_clr;

	// shared adder
	logic [pts_pkg::TIME_W-1:0]   add_b;
	logic                         add_sub;
	logic [pts_pkg::TIME_W-1:0]   add_sum;

	// result register
	pts_pkg::rsp_t                rsp_q, rsp_d;
	logic                         rsp_valid_q;
	logic                         rsp_load;
	logic                         rsp_free;

	logic                         req_fire;
	logic                         cur_valid;
	logic                         key_hit;
	logic                         is_due;
	logic                         at_last;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign cur_valid = valid_q[idx_q];
	assign key_hit   = cur_valid && (key_rd_q == id_q);
	assign is_due    = cur_valid && (now_q >= due_rd_q);
	assign at_last   = (idx_q == LAST_IDX);

	// shared adder: lateness while scanning, new due times otherwise
	always_comb begin
		unique case (state_q)
			S_FIRE: begin
				add_b   = per_rd_q;
				add_sub = 1'b0;
			end
			S_PLACE: begin
				add_b   = dly_q;
				add_sub = 1'b0;
			end
			default: begin
				add_b   = due_rd_q;
				add_sub = 1'b1;
			end
		endcase
		add_sum = now_q + (add_sub ? ~add_b : add_b) + {{(pts_pkg::TIME_W-1){1'b0}}, add_sub};
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		pick_d      = pick_q;
		have_pick_d = have_pick_q;
		ok_d        = ok_q;
		rsp_load    = 1'b0;
		rsp_d       = '0;
		slot_wr     = 1'b0;
		due_wr      = 1'b0;
		vld_set     = 1'b0;
		vld_clr     = 1'b0;
		wr_addr     = idx_q;
		unique case (state_q)
			S_IDLE: begin
				idx_d = '0;
				if (req_fire) begin
					pick_d      = '0;
					have_pick_d = 1'b0;
					unique case (kind)
						pts_pkg::KIND_TICK: begin
							if (now_ticks == last_poll_q) begin
								ok_d    = 1'b0;
								state_d = S_DONE;
							end else begin
								ok_d    = 1'b1;
								state_d = S_SCAN;
							end
						end
						pts_pkg::KIND_ADD, pts_pkg::KIND_REMOVE: begin
							state_d = S_SCAN;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				unique case (kind_q)
					pts_pkg::KIND_TICK: begin
						if (is_due) begin
							if (rsp_free) begin
								rsp_load   = 1'b1;
								rsp_d.kind = pts_pkg::RES_FIRED;
								rsp_d.slot = pts_pkg::SLOT_OUT_W'(idx_q);
								rsp_d.ok   = 1'b1;
								rsp_d.id   = pts_pkg::TASK_ID_W'(key_rd_q);
								rsp_d.late = add_sum;
								rsp_d.last = 1'b0;
								state_d    = S_FIRE;
							end
						end else if (at_last) begin
							state_d = S_DONE;
						end else begin
							idx_d = idx_q + SLOT_W'(1);
						end
					end
					pts_pkg::KIND_ADD: begin
						if (key_hit) begin
							pick_d  = idx_q;
							state_d = S_PLACE;
						end else begin
							if (!cur_valid && !have_pick_q) begin
								pick_d      = idx_q;
								have_pick_d = 1'b1;
							end
							if (at_last) begin
								if (have_pick_q || !cur_valid) begin
									state_d = S_PLACE;
								end else begin
									ok_d    = 1'b0;
									pick_d  = '0;
									state_d = S_REPLY;
								end
							end else begin
								idx_d = idx_q + SLOT_W'(1);
							end
						end
					end
					pts_pkg::KIND_REMOVE: begin
						if (key_hit) begin
							vld_clr = 1'b1;
							pick_d  = idx_q;
							ok_d    = 1'b1;
							state_d = S_REPLY;
						end else if (at_last) begin
							pick_d  = '0;
							ok_d    = 1'b0;
							state_d = S_REPLY;
						end else begin
							idx_d = idx_q + SLOT_W'(1);
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_FIRE: begin
				// reschedule the fired slot at now plus its interval
				due_wr = 1'b1;
				if (at_last) begin
					state_d = S_DONE;
				end else begin
					idx_d   = idx_q + SLOT_W'(1);
					state_d = S_SCAN;
				end
			end
			S_PLACE: begin
				wr_addr = pick_q;
				if (rsp_free) begin
					slot_wr    = 1'b1;
					vld_set    = 1'b1;
					rsp_load   = 1'b1;
					rsp_d.kind = pts_pkg::RES_ADD;
					rsp_d.slot = pts_pkg::SLOT_OUT_W'(pick_q);
					rsp_d.ok   = 1'b1;
					rsp_d.last = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_REPLY: begin
				if (rsp_free) begin
					rsp_load   = 1'b1;
					rsp_d.kind = (kind_q == pts_pkg::KIND_ADD) ? pts_pkg::RES_ADD
					                                           : pts_pkg::RES_REMOVE;
					rsp_d.slot = pts_pkg::SLOT_OUT_W'(pick_q);
					rsp_d.ok   = ok_q;
					rsp_d.last = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_load   = 1'b1;
					rsp_d.kind = pts_pkg::RES_DONE;
					rsp_d.ok   = ok_q;
					rsp_d.last = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// read address follows the slot the sequencer looks at next
	assign rd_addr = idx_d;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			pick_q      <= '0;
			have_pick_q <= 1'b0;
			ok_q        <= 1'b0;
			last_poll_q <= pts_pkg::POLL_RESET;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			pick_q      <= pick_d;
			have_pick_q <= have_pick_d;
			ok_q        <= ok_d;
			if (req_fire && (kind == pts_pkg::KIND_TICK)) begin
				last_poll_q <= now_ticks;
			end
			if (vld_set) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (vld_clr) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item capture and result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q <= kind;
			now_q  <= now_ticks;
			id_q   <= ID_BITS'(task_id);
			per_q  <= period;
			dly_q  <= start_delay;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// slot table memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (slot_wr) begin
			key_mem[wr_addr] <= id_q;
			per_mem[wr_addr] <= per_q;
		end
		if (slot_wr || due_wr) begin
			due_mem[wr_addr] <= add_sum;
		end
		key_rd_q <= key_mem[rd_addr];
		per_rd_q <= per_mem[rd_addr];
		due_rd_q <= due_mem[rd_addr];
	end

	assign rsp_valid   = rsp_valid_q;
	assign result_kind = rsp_q.kind;
	assign slot        = rsp_q.slot;
	assign ok          = rsp_q.ok;
	assign fired_id    = rsp_q.id;
	assign lateness    = rsp_q.late;
	assign last        = rsp_q.last;

	// checks
	`PTS_ASSERT_IMPL(a_fired_not_last, rsp_valid && (result_kind == pts_pkg::RES_FIRED), !last, "fired item marked last")
	`PTS_ASSERT(a_fire_after_emit, (state_q == S_SCAN && rsp_load) |=> (state_q == S_FIRE && rsp_valid), "firing emit not followed by reschedule")
	`PTS_ASSERT_IMPL(a_fire_from_scan, state_q == S_FIRE, $past(state_q) == S_SCAN, "reschedule without a scan step")
	`PTS_ASSERT(a_add_busy, (req_fire && kind == pts_pkg::KIND_ADD) |=> req_stall, "add item did not start work")
	`PTS_ASSERT_IMPL(a_done_poll, rsp_load && rsp_d.kind == pts_pkg::RES_DONE && rsp_d.ok, last_poll_q == now_q, "new tick done without poll time update")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic task scheduler unit. A directed table
// covers the field extremes, table full, reuse of a held id, removal misses,
// repeated tick times and wrapping due times. It is followed by random add,
// remove and tick traffic around a small pool of ids. Every result is checked
// against an in-bench copy of the slot table, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int N_SLOTS = pts_pkg::SLOTS_DEFAULT;
	localparam logic [pts_pkg::KIND_W-1:0] KIND_NOP = 2'd3;
	localparam int RAND_ITEMS = 360;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_AT = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_AT = 250;

	typedef struct packed {
		logic [pts_pkg::KIND_W-1:0]    k;
		logic [pts_pkg::TIME_W-1:0]    t;
		logic [pts_pkg::TASK_ID_W-1:0] id;
		logic [pts_pkg::TIME_W-1:0]    per;
		logic [pts_pkg::TIME_W-1:0]    dly;
		logic                          typed;
		pts_pkg::rsp_t                 want;
	} row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                req_valid;
	logic                                req_stall;
	logic [pts_pkg::KIND_W-1:0]          kind;
	logic signed [pts_pkg::TIME_W-1:0]   now_ticks;
	logic [pts_pkg::TASK_ID_W-1:0]       task_id;
	logic signed [pts_pkg::TIME_W-1:0]   period;
	logic signed [pts_pkg::TIME_W-1:0]   start_delay;
	logic                                rsp_valid;
	logic                                rsp_stall;
	logic [pts_pkg::KIND_W-1:0]          result_kind;
	logic [pts_pkg::SLOT_OUT_W-1:0]      slot;
	logic                                ok;
	logic [pts_pkg::TASK_ID_W-1:0]       fired_id;
	logic signed [pts_pkg::TIME_W-1:0]   lateness;
	logic                                last;

	// typed expectation riding along with the offered item
	logic row_typed;
	pts_pkg::rsp_t row_want;

	// bench copy of the slot table
	logic                          tbl_used [N_SLOTS];
	logic [pts_pkg::TASK_ID_W-1:0] tbl_id   [N_SLOTS];
	logic [pts_pkg::TIME_W-1:0]    tbl_ival [N_SLOTS];
	logic [pts_pkg::TIME_W-1:0]    tbl_due  [N_SLOTS];
	logic [pts_pkg::TIME_W-1:0]    poll_time;

	pts_pkg::rsp_t replies_owed[$];
	int   n_bad;
	int   n_taken;
	int   quiet;

	periodic_task_scheduler_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.now_ticks   (now_ticks),
		.task_id     (task_id),
		.period      (period),
		.start_delay (start_delay),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.result_kind (result_kind),
		.slot        (slot),
		.ok          (ok),
		.fired_id    (fired_id),
		.lateness    (lateness),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic pts_pkg::rsp_t mk_rsp(input logic [pts_pkg::KIND_W-1:0] k,
			input logic [pts_pkg::SLOT_OUT_W-1:0] s, input logic o,
			input logic [pts_pkg::TASK_ID_W-1:0] id,
			input logic [pts_pkg::TIME_W-1:0] late, input logic fin);
		pts_pkg::rsp_t r;
		r.kind = k;
		r.slot = s;
		r.ok   = o;
		r.id   = id;
		r.late = late;
		r.last = fin;
		return r;
	endfunction

	function automatic row_t mk_row(input logic [pts_pkg::KIND_W-1:0] k,
			input logic [pts_pkg::TIME_W-1:0] t, input logic [pts_pkg::TASK_ID_W-1:0] id,
			input logic [pts_pkg::TIME_W-1:0] per, input logic [pts_pkg::TIME_W-1:0] dly,
			input logic typed, input pts_pkg::rsp_t want);
		row_t r;
		r.k     = k;
		r.t     = t;
		r.id    = id;
		r.per   = per;
		r.dly   = dly;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	// apply one item to the bench table and list the results it causes
	task automatic run_scheduler(input logic [pts_pkg::KIND_W-1:0] k,
			input logic [pts_pkg::TIME_W-1:0] t, input logic [pts_pkg::TASK_ID_W-1:0] id,
			input logic [pts_pkg::TIME_W-1:0] per, input logic [pts_pkg::TIME_W-1:0] dly,
			output pts_pkg::rsp_t outs[$]);
		int pick;
		bit found;
		outs = {};
		case (k)
			pts_pkg::KIND_ADD: begin
				// reuse a slot holding the id, else the lowest free one
				pick = -1;
				for (int i = 0; i < N_SLOTS; i++) begin
					if (tbl_used[i] && tbl_id[i] == id) begin
						pick = i;
						break;
					end
					if (!tbl_used[i] && pick < 0)
						pick = i;
				end
				if (pick < 0) begin
					outs.push_back(mk_rsp(pts_pkg::RES_ADD, '0, 1'b0, '0, '0, 1'b1));
				end else begin
					tbl_used[pick] = 1'b1;
					tbl_id[pick]   = id;
					tbl_ival[pick] = per;
					tbl_due[pick]  = t + dly;
					outs.push_back(mk_rsp(pts_pkg::RES_ADD, 4'(pick), 1'b1, '0, '0, 1'b1));
				end
			end
			pts_pkg::KIND_REMOVE: begin
				found = 1'b0;
				for (int i = 0; i < N_SLOTS; i++) begin
					if (!found && tbl_used[i] && tbl_id[i] == id) begin
						tbl_used[i] = 1'b0;
						found = 1'b1;
						outs.push_back(mk_rsp(pts_pkg::RES_REMOVE, 4'(i), 1'b1, '0, '0,
							1'b1));
					end
				end
				if (!found)
					outs.push_back(mk_rsp(pts_pkg::RES_REMOVE, '0, 1'b0, '0, '0, 1'b1));
			end
			pts_pkg::KIND_TICK: begin
				if (t == poll_time) begin
					outs.push_back(mk_rsp(pts_pkg::RES_DONE, '0, 1'b0, '0, '0, 1'b1));
				end else begin
					poll_time = t;
					// fire due slots in index order, signed compare
					for (int i = 0; i < N_SLOTS; i++) begin
						if (tbl_used[i] && $signed(t) >= $signed(tbl_due[i])) begin
							outs.push_back(mk_rsp(pts_pkg::RES_FIRED, 4'(i), 1'b1,
								tbl_id[i], t - tbl_due[i], 1'b0));
							tbl_due[i] = t + tbl_ival[i];
						end
					end
					outs.push_back(mk_rsp(pts_pkg::RES_DONE, '0, 1'b1, '0, '0, 1'b1));
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] exp,
			input logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			n_bad++;
		end
	endtask

	// offer one item after a random gap and wait for it to be taken
	task automatic send_item(input row_t r, input bit drain, input int seq);
		int gap;
		int q;
		q = $urandom_range(0, 99);
		if ((seq / 32) % 4 == 3)
			gap = 0;
		else if (q < 50)
			gap = 0;
		else if (q < 85)
			gap = $urandom_range(1, 3);
		else if (q < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (drain && gap == 0)
			gap = 1;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain && replies_owed.size() != 0)
				@(posedge clk);
		end
		req_valid   <= 1'b1;
		kind        <= r.k;
		now_ticks   <= r.t;
		task_id     <= r.id;
		period      <= r.per;
		start_delay <= r.dly;
		row_typed   <= r.typed;
		row_want    <= r.want;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// accepted items feed the table copy, accepted results are checked
	always @(posedge clk) begin : watch
		pts_pkg::rsp_t got;
		pts_pkg::rsp_t want;
		pts_pkg::rsp_t fresh[$];
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet = 0;
		else
			quiet++;
		if (arst_n && req_valid && !req_stall) begin
			n_taken++;
			run_scheduler(kind, now_ticks, task_id, period, start_delay, fresh);
			if (row_typed)
				replies_owed.push_back(row_want);
			else
				foreach (fresh[j])
					replies_owed.push_back(fresh[j]);
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = mk_rsp(result_kind, slot, ok, fired_id, lateness, last);
			if (replies_owed.size() == 0) begin
				$error("result with none awaited: kind %0d slot %0d id %0h",
					got.kind, got.slot, got.id);
				n_bad++;
			end else begin
				want = replies_owed.pop_front();
				check_field("result_kind", 32'(want.kind), 32'(got.kind));
				check_field("slot", 32'(want.slot), 32'(got.slot));
				check_field("ok", 32'(want.ok), 32'(got.ok));
				check_field("fired_id", 32'(want.id), 32'(got.id));
				check_field("lateness", want.late, got.late);
				check_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	// result side stalls, with one long hold-off to back up the block
	initial begin
		int run;
		int hold_left;
		int cyc;
		int q;
		bit level;
		bit held;
		run = 0;
		hold_left = 0;
		cyc = 0;
		level = 1'b0;
		held = 1'b0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && n_taken >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				if (run == 0) begin
					q = $urandom_range(0, 99);
					level = (q >= 55);
					if (q < 55)
						run = $urandom_range(1, 8);
					else if (q < 90)
						run = $urandom_range(1, 3);
					else if (q < 98)
						run = $urandom_range(4, 12);
					else
						run = $urandom_range(20, 60);
				end
				run--;
				rsp_stall <= level && ((cyc / 200) % 4 != 2);
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		row_t plan[$];
		row_t row;
		logic [pts_pkg::TIME_W-1:0] t_now;
		logic [pts_pkg::TIME_W-1:0] per;
		logic [pts_pkg::TIME_W-1:0] dly;
		logic [pts_pkg::TIME_W-1:0] at;
		logic [pts_pkg::TASK_ID_W-1:0] id;
		int r;
		int q;
		int made;
		int seq;
		bit drained;

		n_bad = 0;
		n_taken = 0;
		quiet = 0;
		for (int i = 0; i < N_SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_id[i]   = '0;
			tbl_ival[i] = '0;
			tbl_due[i]  = '0;
		end
		poll_time = pts_pkg::POLL_RESET;

		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		kind        <= pts_pkg::KIND_TICK;
		now_ticks   <= '0;
		task_id     <= '0;
		period      <= '0;
		start_delay <= '0;
		row_typed   <= 1'b0;
		row_want    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: repeated time at reset, misses, extremes, full table
		plan.push_back(mk_row(pts_pkg::KIND_TICK, 32'hFFFF_FFFF, 16'h0, 32'h0, 32'h0, 1'b1,
			mk_rsp(pts_pkg::RES_DONE, 4'd0, 1'b0, 16'h0, 32'h0, 1'b1)));
		plan.push_back(mk_row(pts_pkg::KIND_REMOVE, 32'h0, 16'hFFFF, 32'h0, 32'h0, 1'b1,
			mk_rsp(pts_pkg::RES_REMOVE, 4'd0, 1'b0, 16'h0, 32'h0, 1'b1)));
		plan.push_back(mk_row(KIND_NOP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b0, '0));
		plan.push_back(mk_row(pts_pkg::KIND_ADD, 32'h0, 16'h0, 32'h1, 32'h0, 1'b1,
			mk_rsp(pts_pkg::RES_ADD, 4'd0, 1'b1, 16'h0, 32'h0, 1'b1)));
		plan.push_back(mk_row(pts_pkg::KIND_ADD, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 1'b1,
			mk_rsp(pts_pkg::RES_ADD, 4'd1, 1'b1, 16'h0, 32'h0, 1'b1)));
		// same id again takes its old slot
		plan.push_back(mk_row(pts_pkg::KIND_ADD, 32'd100, 16'h0, 32'd3, 32'hFFFF_FFFB, 1'b1,
			mk_rsp(pts_pkg::RES_ADD, 4'd0, 1'b1, 16'h0, 32'h0, 1'b1)));
		plan.push_back(mk_row(pts_pkg::KIND_TICK, 32'd100, 16'h0, 32'h0, 32'h0, 1'b0, '0));
		plan.push_back(mk_row(pts_pkg::KIND_TICK, 32'd100, 16'h0, 32'h0, 32'h0, 1'b1,
			mk_rsp(pts_pkg::RES_DONE, 4'd0, 1'b0, 16'h0, 32'h0, 1'b1)));
		plan.push_back(mk_row(pts_pkg::KIND_TICK, 32'h8000_0000, 16'h0, 32'h0, 32'h0, 1'b0,
			'0));
		plan.push_back(mk_row(pts_pkg::KIND_TICK, 32'h7FFF_FFFF, 16'h0, 32'h0, 32'h0, 1'b0,
			'0));
		// fill the rest, with a zero and a most negative interval among them
		for (int i = 2; i < N_SLOTS; i++) begin
			per = (i == 2) ? 32'h0 : (i == 3) ? 32'h8000_0000 : 32'(i);
			plan.push_back(mk_row(pts_pkg::KIND_ADD, 32'(i), 16'(i), per, 32'h0, 1'b1,
				mk_rsp(pts_pkg::RES_ADD, 4'(i), 1'b1, 16'h0, 32'h0, 1'b1)));
		end
		plan.push_back(mk_row(pts_pkg::KIND_ADD, 32'h0, 16'h1234, 32'h1, 32'h1, 1'b1,
			mk_rsp(pts_pkg::RES_ADD, 4'd0, 1'b0, 16'h0, 32'h0, 1'b1)));
		plan.push_back(mk_row(pts_pkg::KIND_REMOVE, 32'h0, 16'hFFFF, 32'h0, 32'h0, 1'b1,
			mk_rsp(pts_pkg::RES_REMOVE, 4'd1, 1'b1, 16'h0, 32'h0, 1'b1)));
		plan.push_back(mk_row(pts_pkg::KIND_TICK, 32'h40, 16'h0, 32'h0, 32'h0, 1'b0, '0));
		plan.push_back(mk_row(pts_pkg::KIND_ADD, 32'h40, 16'hFFFF, 32'h1, 32'h0, 1'b1,
			mk_rsp(pts_pkg::RES_ADD, 4'd1, 1'b1, 16'h0, 32'h0, 1'b1)));
		// every slot due at once
		plan.push_back(mk_row(pts_pkg::KIND_TICK, 32'h80, 16'h0, 32'h0, 32'h0, 1'b0, '0));

		seq = 0;
		foreach (plan[i]) begin
			send_item(plan[i], 1'b0, seq);
			seq++;
		end

		// random traffic around a small id pool
		t_now = 32'h80;
		made = 0;
		drained = 1'b0;
		while (made < RAND_ITEMS) begin
			r = $urandom_range(0, 99);
			id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
			if (r < 40) begin
				q = $urandom_range(0, 99);
				if (q < 8)
					t_now = t_now;
				else if (q < 80)
					t_now = t_now + $urandom_range(1, 6);
				else if (q < 90)
					t_now = t_now + $urandom_range(7, 300);
				else if (q < 95)
					t_now = 32'h7FFF_FFF0 + $urandom_range(0, 12);
				else
					t_now = $urandom;
				row = mk_row(pts_pkg::KIND_TICK, t_now, id, $urandom, $urandom, 1'b0, '0);
			end else if (r < 70) begin
				q = $urandom_range(0, 99);
				if (q < 75)
					per = $urandom_range(0, 8);
				else if (q < 85)
					per = 0 - $urandom_range(1, 4);
				else
					per = $urandom;
				q = $urandom_range(0, 99);
				if (q < 70)
					dly = $urandom_range(0, 6);
				else if (q < 85)
					dly = 0 - $urandom_range(1, 6);
				else
					dly = $urandom;
				at = ($urandom_range(0, 99) < 85) ? t_now : $urandom;
				row = mk_row(pts_pkg::KIND_ADD, at, id, per, dly, 1'b0, '0);
			end else if (r < 94) begin
				row = mk_row(pts_pkg::KIND_REMOVE, $urandom, id, $urandom, $urandom, 1'b0,
					'0);
			end else begin
				row = mk_row(KIND_NOP, $urandom, 16'($urandom), $urandom, $urandom, 1'b0, '0);
			end
			send_item(row, !drained && made == DRAIN_AT, seq);
			if (made == DRAIN_AT)
				drained = 1'b1;
			if (row.k != KIND_NOP)
				made++;
			seq++;
		end
		req_valid <= 1'b0;

		while (replies_owed.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (n_bad == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
